/* rtl/ile_pkg.sv */
// Package for the indexed list engine: operation codes, cell commands and
// field widths shared by the cell row and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

	// Field widths of the stream payloads.
	localparam int KIND_W      = 3;
	localparam int POS_W       = 6;
	localparam int ITEM_W      = 64;
	localparam int STATUS_W    = 1;
	localparam int COUNT_W     = 7;
	localparam int S_TDATA_W   = 72;
	localparam int M_TDATA_W   = 80;

	// Bit offsets inside the stream payloads.
	localparam int S_ITEM_LSB  = POS_W;
	localparam int M_FOUND_LSB = ITEM_W;
	localparam int M_COUNT_LSB = ITEM_W + POS_W;
	localparam int M_USED_W    = ITEM_W + POS_W + COUNT_W;

	// Operation codes carried in the input tuser.
	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND       = 3'd0,
		KIND_INSERT       = 3'd1,
		KIND_SEARCH       = 3'd2,
		KIND_REMOVE_LAST  = 3'd3,
		KIND_REMOVE_FIRST = 3'd4,
		KIND_REMOVE_AT    = 3'd5,
		KIND_READ_AT      = 3'd6
	} kind_t;

	// Status codes carried in the output tuser.
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	// Change applied to the row of cells when an operation completes.
	typedef enum logic [2:0] {
		CELL_NONE   = 3'd0,
		CELL_APPEND = 3'd1,
		CELL_INSERT = 3'd2,
		CELL_REMOVE = 3'd3,
		CELL_DROP   = 3'd4
	} cell_op_t;

	// Commands broadcast from the controller to every cell.
	typedef struct packed {
		cell_op_t op;
		logic     search;
		logic     take;
		logic     commit;
	} ile_ctrl_t;

endpackage

`default_nettype wire

/* rtl/indexed_list_engine.sv */
// Indexed list engine: an ordered list kept in a row of CAPACITY cells.
// An operation completes once the probe has crossed every cell and the output
// register is free; a new one is taken only after that, as every kind waits
// for the probe that ripples through the cell row one cell per cycle. Reset
// clears the fill count and the controller; entry contents stay unknown and
// are never read before they are written. Depends on ile_pkg, ile_cell.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_engine #(
	parameter int CAPACITY   = 64,
	parameter int ITEM_WIDTH = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// tdata: position[5:0], item_in[69:6], zero fill above.
	input  wire  [ile_pkg::S_TDATA_W-1:0]    s_tdata,
	// tuser: kind[2:0].
	input  wire  [ile_pkg::KIND_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// tdata: item_out[63:0], found_position[69:64], count[76:70], zero fill above.
	output logic [ile_pkg::M_TDATA_W-1:0]    m_tdata,
	// tuser: status[0].
	output logic [ile_pkg::STATUS_W-1:0]     m_tuser
);

	localparam int IDXW   = $clog2(CAPACITY);
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int WIDE_W = (CW > ile_pkg::COUNT_W) ? CW : ile_pkg::COUNT_W;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_PROBE = 2'b10
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              cnt_q;
	ile_pkg::cell_op_t          op_q;
	logic                       fail_q;
	logic                       search_q;
	logic                       take_q;
	logic [ITEM_WIDTH-1:0]      key_q;
	logic [IDXW-1:0]            tpos_q;

	logic                       m_tvalid_q;
	logic                       status_q;
	logic [ITEM_WIDTH-1:0]      item_out_q;
	logic [IDXW-1:0]            found_q;
	logic [CW-1:0]              count_out_q;

	logic                       accept;
	logic                       commit;
	logic [ile_pkg::KIND_W-1:0] kind_in;
	logic [WIDE_W-1:0]          pos_wide;
	logic [ITEM_WIDTH-1:0]      key_in;
	logic                       full;
	logic                       empty;
	logic                       in_range;
	logic                       dec_ok;
	logic                       dec_search;
	logic                       dec_take;
	ile_pkg::cell_op_t          dec_op;
	logic [IDXW-1:0]            dec_tpos;
	logic                       done_fail;
	logic [CW-1:0]              count_next;
	logic [WIDE_W-1:0]          found_wide;
	logic [WIDE_W-1:0]          count_wide;

	ile_pkg::ile_ctrl_t         ctrl;

	logic [ITEM_WIDTH-1:0]      ent   [CAPACITY];
	logic                       hit_c [CAPACITY+1];
	logic [IDXW-1:0]            idx_c [CAPACITY+1];
	logic [ITEM_WIDTH-1:0]      data_c[CAPACITY+1];

	// Field extraction from the input transfer.
	always_comb begin
		kind_in  = s_tuser;
		pos_wide = WIDE_W'(s_tdata[ile_pkg::POS_W-1:0]);
		key_in   = s_tdata[ile_pkg::S_ITEM_LSB +: ITEM_WIDTH];
		full     = count_q == CW'(CAPACITY);
		empty    = count_q == '0;
		in_range = pos_wide < WIDE_W'(count_q);
	end

	// Operation decode: range checks and the target cell.
	always_comb begin
		dec_ok     = 1'b0;
		dec_search = 1'b0;
		dec_take   = 1'b0;
		dec_op     = ile_pkg::CELL_NONE;
		dec_tpos   = pos_wide[IDXW-1:0];
		unique case (kind_in)
			ile_pkg::KIND_APPEND: begin
				dec_ok = !full;
				dec_op = ile_pkg::CELL_APPEND;
			end
			ile_pkg::KIND_INSERT: begin
				dec_ok = (key_in != '0) && in_range && !full;
				dec_op = ile_pkg::CELL_INSERT;
			end
			ile_pkg::KIND_SEARCH: begin
				dec_ok     = key_in != '0;
				dec_search = 1'b1;
			end
			ile_pkg::KIND_REMOVE_LAST: begin
				dec_ok   = !empty;
				dec_take = 1'b1;
				dec_op   = ile_pkg::CELL_DROP;
				dec_tpos = IDXW'(count_q - CW'(1));
			end
			ile_pkg::KIND_REMOVE_FIRST: begin
				dec_ok   = !empty;
				dec_take = 1'b1;
				dec_op   = ile_pkg::CELL_REMOVE;
				dec_tpos = '0;
			end
			ile_pkg::KIND_REMOVE_AT: begin
				dec_ok   = in_range;
				dec_take = 1'b1;
				dec_op   = ile_pkg::CELL_REMOVE;
			end
			ile_pkg::KIND_READ_AT: begin
				dec_ok   = in_range;
				dec_take = 1'b1;
			end
			default: begin
				dec_ok = 1'b0;
			end
		endcase
	end

	// Handshake and completion of the probe.
	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign commit   = (state_q == ST_PROBE) && (cnt_q == CW'(CAPACITY)) &&
	                  (!m_tvalid_q || m_tready);

	// Result of the finished operation and the new fill count.
	always_comb begin
		done_fail  = fail_q || (search_q && !hit_c[CAPACITY]);
		count_next = count_q;
		if (!fail_q) begin
			unique case (op_q)
				ile_pkg::CELL_APPEND,
				ile_pkg::CELL_INSERT: count_next = count_q + CW'(1);
				ile_pkg::CELL_REMOVE,
				ile_pkg::CELL_DROP:   count_next = count_q - CW'(1);
				default:              count_next = count_q;
			endcase
		end
	end

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			cnt_q    <= '0;
			op_q     <= ile_pkg::CELL_NONE;
			fail_q   <= 1'b0;
			search_q <= 1'b0;
			take_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q  <= ST_PROBE;
						cnt_q    <= '0;
						op_q     <= dec_ok ? dec_op : ile_pkg::CELL_NONE;
						fail_q   <= !dec_ok;
						search_q <= dec_ok && dec_search;
						take_q   <= dec_ok && dec_take;
					end
				end
				ST_PROBE: begin
					if (cnt_q != CW'(CAPACITY)) cnt_q <= cnt_q + CW'(1);
					if (commit) begin
						state_q  <= ST_IDLE;
						count_q  <= count_next;
						op_q     <= ile_pkg::CELL_NONE;
						search_q <= 1'b0;
						take_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operands held for the whole operation.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= key_in;
			tpos_q <= dec_tpos;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q    <= done_fail ? ile_pkg::STATUS_FAIL : ile_pkg::STATUS_OK;
			item_out_q  <= take_q ? data_c[CAPACITY] : '0;
			found_q     <= (search_q && !done_fail) ? idx_c[CAPACITY] : '0;
			count_out_q <= count_next;
		end
	end

	// Commands to the cell row.
	always_comb begin
		ctrl.op     = op_q;
		ctrl.search = search_q;
		ctrl.take   = take_q;
		ctrl.commit = commit;
	end

	// Row of cells; the probe enters at cell zero with nothing found.
	assign hit_c[0]  = 1'b0;
	assign idx_c[0]  = '0;
	assign data_c[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ITEM_WIDTH-1:0] left_e;
		logic [ITEM_WIDTH-1:0] right_e;

		if (i == 0) begin : g_first
			assign left_e = '0;
		end else begin : g_mid_l
			assign left_e = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_mid_r
			assign right_e = ent[i+1];
		end

		ile_cell #(
			.ITEM_WIDTH (ITEM_WIDTH),
			.CAPACITY   (CAPACITY),
			.INDEX      (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.key         (key_q),
			.tpos        (tpos_q),
			.count       (count_q),
			.left_entry  (left_e),
			.right_entry (right_e),
			.entry       (ent[i]),
			.hit_in      (hit_c[i]),
			.idx_in      (idx_c[i]),
			.data_in     (data_c[i]),
			.hit_out     (hit_c[i+1]),
			.idx_out     (idx_c[i+1]),
			.data_out    (data_c[i+1])
		);
	end

	// Output packing.
	always_comb begin
		found_wide = WIDE_W'(found_q);
		count_wide = WIDE_W'(count_out_q);
		m_tdata    = '0;
		m_tdata[ile_pkg::ITEM_W-1:0] = ile_pkg::ITEM_W'(item_out_q);
		m_tdata[ile_pkg::M_FOUND_LSB +: ile_pkg::POS_W]   = found_wide[ile_pkg::POS_W-1:0];
		m_tdata[ile_pkg::M_COUNT_LSB +: ile_pkg::COUNT_W] = count_wide[ile_pkg::COUNT_W-1:0];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	// An operation completes only after the probe has crossed every cell.
	a_commit_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (cnt_q == CW'(CAPACITY)))
		else $error("completion before the probe left the row");

	// An accepted transfer starts a fresh probe.
	a_probe_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_PROBE) && (cnt_q == '0))
		else $error("probe did not start on input transfer");

	// A successful append or insert grows the list by one.
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !fail_q && (op_q == ile_pkg::CELL_APPEND || op_q == ile_pkg::CELL_INSERT))
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("count did not grow on append or insert");

	// A completed operation always presents its result next cycle.
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_tvalid_q)
		else $error("result lost on completion");

endmodule

`default_nettype wire

/* rtl/ile_cell.sv */
// One cell of the list row: holds a single entry, takes part in the probe
// that ripples along the row, and shifts with its neighbors on insert/remove.
// Depends on ile_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ile_cell #(
	parameter int ITEM_WIDTH = 64,
	parameter int CAPACITY   = 64,
	parameter int INDEX      = 0
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  ile_pkg::ile_ctrl_t                ctrl,
	input  wire  [ITEM_WIDTH-1:0]             key,
	input  wire  [$clog2(CAPACITY)-1:0]       tpos,
	input  wire  [$clog2(CAPACITY+1)-1:0]     count,
	input  wire  [ITEM_WIDTH-1:0]             left_entry,
	input  wire  [ITEM_WIDTH-1:0]             right_entry,
	output logic [ITEM_WIDTH-1:0]             entry,
	input  wire                               hit_in,
	input  wire  [$clog2(CAPACITY)-1:0]       idx_in,
	input  wire  [ITEM_WIDTH-1:0]             data_in,
	output logic                              hit_out,
	output logic [$clog2(CAPACITY)-1:0]       idx_out,
	output logic [ITEM_WIDTH-1:0]             data_out
);

	localparam int IDXW = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);

	logic [ITEM_WIDTH-1:0] entry_q;
	logic                  hit_q;
	logic [IDXW-1:0]       idx_q;
	logic [ITEM_WIDTH-1:0] data_q;

	logic below_count;
	logic upto_count;
	logic next_below;
	logic at_count;
	logic at_pos;
	logic after_pos;
	logic match;

	// Position of this cell relative to the fill count and the target.
	always_comb begin
		below_count = CW'(INDEX) < count;
		upto_count  = CW'(INDEX) <= count;
		next_below  = CW'(INDEX + 1) < count;
		at_count    = CW'(INDEX) == count;
		at_pos      = IDXW'(INDEX) == tpos;
		after_pos   = IDXW'(INDEX) > tpos;
		match       = ctrl.search && below_count && !hit_in && (entry_q == key);
	end

	// Probe stage: pass the first match and the entry at the target along.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= hit_in | match;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= match ? IDXW'(INDEX) : idx_in;
		data_q <= (ctrl.take && at_pos) ? entry_q : data_in;
	end

	// Entry update when the operation completes.
	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			unique case (ctrl.op)
				ile_pkg::CELL_APPEND: begin
					if (at_count) entry_q <= key;
				end
				ile_pkg::CELL_INSERT: begin
					if (at_pos) entry_q <= key;
					else if (after_pos && upto_count) entry_q <= left_entry;
				end
				ile_pkg::CELL_REMOVE: begin
					if (!after_pos && !at_pos) entry_q <= entry_q;
					else if (next_below) entry_q <= right_entry;
				end
				default: begin
					entry_q <= entry_q;
				end
			endcase
		end
	end

	assign entry    = entry_q;
	assign hit_out  = hit_q;
	assign idx_out  = idx_q;
	assign data_out = data_q;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for indexed_list_engine: directed and random list operations
// are streamed in, every result is predicted by a behavioral list and compared.
// Depends on ile_pkg and the indexed_list_engine RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int CAPACITY    = 64;
	localparam int LATENCY     = CAPACITY + 2;
	localparam int RANDOM_OPS  = 450;
	localparam int RUN_LIMIT   = 400000;
	localparam int HOLD_START  = 3000;
	localparam int HOLD_LEN    = 600;
	localparam int QUIET_START = 12000;
	localparam int QUIET_END   = 20000;

	// The kind code that names no operation.
	localparam logic [ile_pkg::KIND_W-1:0] KIND_UNUSED = 3'd7;

	typedef struct packed {
		logic [ile_pkg::KIND_W-1:0] kind;
		logic [ile_pkg::POS_W-1:0]  pos;
		logic [ile_pkg::ITEM_W-1:0] item;
	} list_req_t;

	typedef struct packed {
		logic                        status;
		logic [ile_pkg::ITEM_W-1:0]  item;
		logic [ile_pkg::POS_W-1:0]   found;
		logic [ile_pkg::COUNT_W-1:0] count;
	} list_result_t;

	typedef struct packed {
		logic [CAPACITY-1:0][ile_pkg::ITEM_W-1:0] cells;
		logic [ile_pkg::COUNT_W-1:0]              fill;
	} list_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ile_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [ile_pkg::KIND_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [ile_pkg::M_TDATA_W-1:0] m_tdata;
	logic [ile_pkg::STATUS_W-1:0] m_tuser;

	list_req_t    op_queue[$];
	list_result_t due_results[$];
	list_state_t  plan_list;
	list_state_t  model_list;
	int           offered_count = 0;
	int           taken_count = 0;
	int           cycle_count = 0;
	int           hold_left = 0;
	int           error_count = 0;

	indexed_list_engine #(
		.CAPACITY(CAPACITY),
		.ITEM_WIDTH(ile_pkg::ITEM_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// Apply one operation to a list and return the result it yields.
	// A failed operation leaves the list as it was.
	function automatic list_result_t step_list(inout list_state_t st, input list_req_t req);
		list_result_t res;
		int unsigned n;
		int idx;
		int at;
		bit hit;
		res = '0;
		res.status = ile_pkg::STATUS_FAIL;
		n = st.fill;
		hit = 1'b0;
		case (req.kind)
			ile_pkg::KIND_APPEND: begin
				if (n < CAPACITY) begin
					st.cells[n] = req.item;
					n++;
					res.status = ile_pkg::STATUS_OK;
				end
			end
			ile_pkg::KIND_INSERT: begin
				if (req.item != '0 && req.pos < n && n < CAPACITY) begin
					for (idx = n; idx > req.pos; idx--)
						st.cells[idx] = st.cells[idx-1];
					st.cells[req.pos] = req.item;
					n++;
					res.status = ile_pkg::STATUS_OK;
				end
			end
			ile_pkg::KIND_SEARCH: begin
				if (req.item != '0) begin
					for (idx = 0; idx < n; idx++) begin
						if (!hit && st.cells[idx] == req.item) begin
							hit = 1'b1;
							res.found = idx[ile_pkg::POS_W-1:0];
							res.status = ile_pkg::STATUS_OK;
						end
					end
				end
			end
			ile_pkg::KIND_REMOVE_LAST: begin
				if (n > 0) begin
					res.item = st.cells[n-1];
					n--;
					res.status = ile_pkg::STATUS_OK;
				end
			end
			ile_pkg::KIND_REMOVE_FIRST, ile_pkg::KIND_REMOVE_AT: begin
				at = (req.kind == ile_pkg::KIND_REMOVE_FIRST) ? 0 : int'(req.pos);
				if (at < n) begin
					res.item = st.cells[at];
					for (idx = at + 1; idx < n; idx++)
						st.cells[idx-1] = st.cells[idx];
					n--;
					res.status = ile_pkg::STATUS_OK;
				end
			end
			ile_pkg::KIND_READ_AT: begin
				if (req.pos < n) begin
					res.item = st.cells[req.pos];
					res.status = ile_pkg::STATUS_OK;
				end
			end
			default: begin
			end
		endcase
		st.fill = n[ile_pkg::COUNT_W-1:0];
		res.count = n[ile_pkg::COUNT_W-1:0];
		return res;
	endfunction

	// Queue an operation and keep the planning copy of the list in step with it.
	task automatic queue_op(input logic [ile_pkg::KIND_W-1:0] kind, input int pos,
			input logic [ile_pkg::ITEM_W-1:0] item);
		list_req_t req;
		req.kind = kind;
		req.pos = pos[ile_pkg::POS_W-1:0];
		req.item = item;
		void'(step_list(plan_list, req));
		op_queue.push_back(req);
	endtask

	task automatic report_mismatch(input string what, input logic [ile_pkg::ITEM_W-1:0] got,
			input logic [ile_pkg::ITEM_W-1:0] want);
		$display("mismatch at cycle %0d: %s: got %h, expected %h", cycle_count, what, got,
			want);
		error_count++;
	endtask

	// Item words: some zeros, a small pool that makes duplicates, otherwise any word.
	function automatic logic [ile_pkg::ITEM_W-1:0] pick_item();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return '0;
		else if (roll < 40)
			return ile_pkg::ITEM_W'($urandom_range(8, 1));
		else
			return {$urandom, $urandom};
	endfunction

	// Growing phases favor appends and inserts, shrinking phases favor removals.
	function automatic logic [ile_pkg::KIND_W-1:0] pick_kind(input bit growing);
		int roll;
		roll = $urandom_range(99);
		if (growing) begin
			if (roll < 35) return ile_pkg::KIND_APPEND;
			if (roll < 58) return ile_pkg::KIND_INSERT;
			if (roll < 72) return ile_pkg::KIND_SEARCH;
			if (roll < 82) return ile_pkg::KIND_READ_AT;
			if (roll < 88) return ile_pkg::KIND_REMOVE_AT;
			if (roll < 92) return ile_pkg::KIND_REMOVE_FIRST;
			if (roll < 96) return ile_pkg::KIND_REMOVE_LAST;
			if (roll < 98) return KIND_UNUSED;
			return ile_pkg::KIND_APPEND;
		end
		if (roll < 8) return ile_pkg::KIND_APPEND;
		if (roll < 14) return ile_pkg::KIND_INSERT;
		if (roll < 28) return ile_pkg::KIND_SEARCH;
		if (roll < 38) return ile_pkg::KIND_READ_AT;
		if (roll < 58) return ile_pkg::KIND_REMOVE_AT;
		if (roll < 76) return ile_pkg::KIND_REMOVE_FIRST;
		if (roll < 96) return ile_pkg::KIND_REMOVE_LAST;
		if (roll < 98) return KIND_UNUSED;
		return ile_pkg::KIND_SEARCH;
	endfunction

	// Cycle counter and run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// One long hold-off of the receiver while the sender keeps offering.
	always @(posedge clk) begin
		if (cycle_count == HOLD_START)
			hold_left <= HOLD_LEN;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Input driver: a pending transfer is held until taken, otherwise the next
	// operation is offered unless the sender idles this cycle.
	always @(negedge clk) begin : drive_input
		list_req_t next_req;
		bit quiet;
		quiet = cycle_count >= QUIET_START && cycle_count < QUIET_END;
		if (arst_n && !(s_tvalid && taken_count != offered_count)) begin
			if (op_queue.size() != 0 && (quiet || $urandom_range(99) >= 15)) begin
				next_req = op_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {{(ile_pkg::S_TDATA_W - ile_pkg::ITEM_W - ile_pkg::POS_W){1'b0}},
					next_req.item, next_req.pos};
				s_tuser <= next_req.kind;
				offered_count <= offered_count + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output ready: random stalls, none in the quiet stretch, held low during the hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0)
				m_tready <= 1'b0;
			else if (cycle_count >= QUIET_START && cycle_count < QUIET_END)
				m_tready <= 1'b1;
			else
				m_tready <= $urandom_range(99) >= 15;
		end
	end

	// Every accepted input transfer is predicted from what was on the bus.
	always @(posedge clk) begin : predict_input
		list_req_t req;
		if (arst_n && s_tvalid && s_tready) begin
			req.kind = s_tuser;
			req.pos = s_tdata[ile_pkg::POS_W-1:0];
			req.item = s_tdata[ile_pkg::S_ITEM_LSB +: ile_pkg::ITEM_W];
			due_results.push_back(step_list(model_list, req));
			taken_count <= taken_count + 1;
		end
	end

	// Every output transfer is checked field by field against the oldest prediction.
	always @(posedge clk) begin : check_output
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing due", m_tdata[ile_pkg::ITEM_W-1:0], '0);
			end else begin
				want = due_results.pop_front();
				if (m_tuser[0] !== want.status)
					report_mismatch("status", ile_pkg::ITEM_W'(m_tuser[0]),
						ile_pkg::ITEM_W'(want.status));
				if (m_tdata[ile_pkg::ITEM_W-1:0] !== want.item)
					report_mismatch("item_out", m_tdata[ile_pkg::ITEM_W-1:0], want.item);
				if (m_tdata[ile_pkg::M_FOUND_LSB +: ile_pkg::POS_W] !== want.found)
					report_mismatch("found_position",
						ile_pkg::ITEM_W'(m_tdata[ile_pkg::M_FOUND_LSB +: ile_pkg::POS_W]),
						ile_pkg::ITEM_W'(want.found));
				if (m_tdata[ile_pkg::M_COUNT_LSB +: ile_pkg::COUNT_W] !== want.count)
					report_mismatch("count",
						ile_pkg::ITEM_W'(m_tdata[ile_pkg::M_COUNT_LSB +: ile_pkg::COUNT_W]),
						ile_pkg::ITEM_W'(want.count));
			end
		end
	end

	initial begin
		int n;
		int pos;
		bit growing;
		logic [ile_pkg::KIND_W-1:0] kind;
		logic [ile_pkg::ITEM_W-1:0] item;
		plan_list = '0;
		model_list = '0;

		// Directed: empty list, zero items, extremes of the word and of the position.
		queue_op(ile_pkg::KIND_REMOVE_LAST, 0, '0);
		queue_op(ile_pkg::KIND_REMOVE_FIRST, 0, '0);
		queue_op(ile_pkg::KIND_READ_AT, 0, '0);
		queue_op(ile_pkg::KIND_REMOVE_AT, 0, '0);
		queue_op(ile_pkg::KIND_SEARCH, 0, 64'h1);
		queue_op(ile_pkg::KIND_INSERT, 0, 64'h1);
		queue_op(ile_pkg::KIND_APPEND, 63, '0);
		queue_op(ile_pkg::KIND_APPEND, 0, '1);
		queue_op(ile_pkg::KIND_APPEND, 0, 64'h1);
		queue_op(ile_pkg::KIND_INSERT, 0, '0);
		queue_op(ile_pkg::KIND_SEARCH, 0, '0);
		queue_op(ile_pkg::KIND_INSERT, 1, 64'h8000_0000_0000_0000);
		queue_op(ile_pkg::KIND_SEARCH, 0, '1);
		queue_op(ile_pkg::KIND_SEARCH, 0, 64'h1);
		queue_op(ile_pkg::KIND_SEARCH, 0, 64'h5555_5555_5555_5555);
		queue_op(ile_pkg::KIND_READ_AT, 0, '0);
		queue_op(ile_pkg::KIND_READ_AT, 63, '0);
		queue_op(ile_pkg::KIND_REMOVE_AT, 4, '0);
		queue_op(ile_pkg::KIND_REMOVE_AT, 1, '0);
		queue_op(ile_pkg::KIND_REMOVE_FIRST, 0, '0);
		queue_op(KIND_UNUSED, 63, '1);
		queue_op(ile_pkg::KIND_REMOVE_LAST, 0, '0);
		queue_op(ile_pkg::KIND_INSERT, 0, 64'hAAAA_AAAA_AAAA_AAAA);
		queue_op(ile_pkg::KIND_READ_AT, 0, '0);

		// Random: alternate growing and shrinking so the list runs between empty and full.
		growing = 1'b1;
		for (int i = 0; i < RANDOM_OPS; i++) begin
			n = plan_list.fill;
			if (growing && n == CAPACITY && $urandom_range(5) == 0)
				growing = 1'b0;
			else if (!growing && n == 0 && $urandom_range(3) == 0)
				growing = 1'b1;
			kind = pick_kind(growing);
			if (n > 0 && $urandom_range(99) < 70)
				pos = $urandom_range(n);
			else
				pos = $urandom_range(63);
			item = pick_item();
			// Searches mostly look for a word the list holds.
			if (kind == ile_pkg::KIND_SEARCH && n > 0 && $urandom_range(99) < 60)
				item = plan_list.cells[$urandom_range(n - 1)];
			queue_op(kind, pos, item);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_queue.size() != 0 || taken_count != offered_count || s_tvalid)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		if (error_count == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

/* indexed_list_engine.f */
rtl/ile_pkg.sv
rtl/ile_cell.sv
rtl/indexed_list_engine.sv
tb/sv/testbench.sv
